>>> design/plht_pkg.sv
// Package for the polyline edge hit test block.
// Opcodes, register indexes, state and datapath command types.
// No dependencies.
`timescale 1ns / 1ps
package plht_pkg;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [1:0] CFG_STROKE = 2'd0;
  localparam logic [1:0] CFG_PAD    = 2'd1;
  localparam logic [1:0] CFG_GRIP   = 2'd2;

  localparam int CFG_W      = 12;
  localparam int D2_W       = 37;
  localparam int MAC_STEPS  = 4;
  localparam int DIV_STEPS  = 16;
  localparam int ROOT_STEPS = 19;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_LD, ST_MAC, ST_CHK, ST_DIV, ST_OFS, ST_SQ, ST_NXT, ST_ROOT, ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    DP_NOP, DP_CLEAR, DP_APPEND, DP_QINIT, DP_LOAD, DP_MAC, DP_CHK, DP_DIV,
    DP_OFS, DP_SQ, DP_NEXT, DP_ROOT, DP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_lt2;
    logic seg_last;
    logic need_div;
  } dp_status_t;

endpackage

>>> design/plht_ram.sv
// Generic RAM: one write port, two registered read ports.
// No dependencies.
`timescale 1ns / 1ps
module plht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end
endmodule

>>> design/plht_ctrl.sv
// Controller for the polyline edge hit test: sequences segments and steps.
// Depends on plht_pkg.
`timescale 1ns / 1ps
module plht_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic [1:0]          opcode_i,
  input  plht_pkg::dp_status_t status_i,
  output plht_pkg::dp_cmd_t    cmd_o,
  output logic                busy
);
  plht_pkg::state_e state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       accept;

  assign accept = start && (state_q == plht_pkg::ST_IDLE);
  assign busy   = (state_q != plht_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plht_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = '0;
    unique case (state_q)
      plht_pkg::ST_IDLE: begin
        if (accept && opcode_i == plht_pkg::OP_QUERY) begin
          state_d = status_i.cnt_lt2 ? plht_pkg::ST_DONE : plht_pkg::ST_RD;
        end
      end
      plht_pkg::ST_RD:  state_d = plht_pkg::ST_LD;
      plht_pkg::ST_LD:  state_d = plht_pkg::ST_MAC;
      plht_pkg::ST_MAC: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(plht_pkg::MAC_STEPS - 1)) begin
          state_d = plht_pkg::ST_CHK;
          cnt_d   = '0;
        end
      end
      plht_pkg::ST_CHK: state_d = status_i.need_div ? plht_pkg::ST_DIV : plht_pkg::ST_SQ;
      plht_pkg::ST_DIV: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(plht_pkg::DIV_STEPS - 1)) begin
          state_d = plht_pkg::ST_OFS;
          cnt_d   = '0;
        end
      end
      plht_pkg::ST_OFS: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd1) begin
          state_d = plht_pkg::ST_SQ;
          cnt_d   = '0;
        end
      end
      plht_pkg::ST_SQ: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd1) begin
          state_d = plht_pkg::ST_NXT;
          cnt_d   = '0;
        end
      end
      plht_pkg::ST_NXT: state_d = status_i.seg_last ? plht_pkg::ST_ROOT : plht_pkg::ST_RD;
      plht_pkg::ST_ROOT: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(plht_pkg::ROOT_STEPS - 1)) begin
          state_d = plht_pkg::ST_DONE;
          cnt_d   = '0;
        end
      end
      plht_pkg::ST_DONE: state_d = plht_pkg::ST_IDLE;
      default:           state_d = plht_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op   = plht_pkg::DP_NOP;
    cmd_o.step = cnt_q[1:0];
    unique case (state_q)
      plht_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (opcode_i)
            plht_pkg::OP_CLEAR:  cmd_o.op = plht_pkg::DP_CLEAR;
            plht_pkg::OP_APPEND: cmd_o.op = plht_pkg::DP_APPEND;
            plht_pkg::OP_QUERY:  cmd_o.op = plht_pkg::DP_QINIT;
            default:             cmd_o.op = plht_pkg::DP_NOP;
          endcase
        end
      end
      plht_pkg::ST_RD:   cmd_o.op = plht_pkg::DP_NOP;
      plht_pkg::ST_LD:   cmd_o.op = plht_pkg::DP_LOAD;
      plht_pkg::ST_MAC:  cmd_o.op = plht_pkg::DP_MAC;
      plht_pkg::ST_CHK:  cmd_o.op = plht_pkg::DP_CHK;
      plht_pkg::ST_DIV:  cmd_o.op = plht_pkg::DP_DIV;
      plht_pkg::ST_OFS:  cmd_o.op = plht_pkg::DP_OFS;
      plht_pkg::ST_SQ:   cmd_o.op = plht_pkg::DP_SQ;
      plht_pkg::ST_NXT:  cmd_o.op = plht_pkg::DP_NEXT;
      plht_pkg::ST_ROOT: cmd_o.op = plht_pkg::DP_ROOT;
      plht_pkg::ST_DONE: cmd_o.op = plht_pkg::DP_OUT;
      default:           cmd_o.op = plht_pkg::DP_NOP;
    endcase
  end
endmodule

>>> design/plht_dp.sv
// Datapath for the polyline edge hit test: vertex store, shared multiplier,
// bit-serial divider and square root. Depends on plht_pkg and plht_ram.
`timescale 1ns / 1ps
module plht_dp #(
  parameter int MAX_VERTICES = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  plht_pkg::dp_cmd_t          cmd_i,
  output plht_pkg::dp_status_t       status_o,
  input  logic signed [15:0]         coord_x_i,
  input  logic signed [15:0]         coord_y_i,
  input  logic                       cfg_valid_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [plht_pkg::CFG_W-1:0] cfg_data_i,
  output logic                       done_o,
  output logic                       hit_o,
  output logic [15:0]                min_distance_o,
  output logic                       no_segment_o,
  output logic                       overflowed_o
);
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = AW + 1;
  localparam int DW = plht_pkg::D2_W;

  logic [11:0] stroke_q;
  logic [7:0]  pad_q;
  logic [9:0]  grip_q;
  logic [CW-1:0] count_q;
  logic          drop_q;
  logic [AW-1:0] seg_q;

  logic signed [15:0] px_q, py_q;
  logic signed [16:0] abx_q, aby_q, apx_q, apy_q, bpx_q, bpy_q;
  logic [35:0]        len2_q;
  logic signed [36:0] dot_q;
  logic [DW-1:0]      rem_q;
  logic [15:0]        t_q;
  logic signed [17:0] dx_q, dy_q;
  logic [DW-1:0]      d2_q, best_q, v_q, res_q, bit_q;
  logic [27:0]        outer2_q, inner2_q;
  logic               inner_neg_q;

  logic [31:0] rd_a, rd_b;
  logic        ram_we;
  logic [AW-1:0] rd_addr_b;

  logic [13:0] outer;
  logic signed [14:0] inner;
  logic [13:0] inner_mag;

  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] prod;
  logic [16:0] rnd;
  logic [DW-1:0] rem2, sq_sum, root_try;
  logic signed [17:0] ofs_delta, ofs_ap;
  logic [38:0] d2x4;

  assign ram_we    = (cmd_i.op == plht_pkg::DP_APPEND) &&
                     (count_q < CW'(MAX_VERTICES));
  assign rd_addr_b = seg_q + AW'(1);

  plht_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_vtx (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (count_q[AW-1:0]),
    .wdata_i   ({coord_x_i, coord_y_i}),
    .raddr_a_i (seg_q),
    .raddr_b_i (rd_addr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  assign status_o.cnt_lt2  = (count_q < CW'(2));
  assign status_o.seg_last = ((CW'(seg_q) + CW'(2)) >= count_q);
  assign status_o.need_div = (len2_q != '0) && (dot_q > 0) &&
                             (37'(len2_q) > $unsigned(dot_q));

  assign outer     = 14'(stroke_q) + {5'd0, pad_q, 1'b0};
  assign inner     = $signed({1'b0, outer}) - $signed(15'(grip_q));
  assign inner_mag = inner[13:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    ofs_delta = (cmd_i.step[0]) ? 18'(aby_q) : 18'(abx_q);
    ofs_ap    = (cmd_i.step[0]) ? 18'(apy_q) : 18'(apx_q);
    unique case (cmd_i.op)
      plht_pkg::DP_MAC: begin
        case (cmd_i.step)
          2'd0:    begin mul_a = 18'(abx_q); mul_b = 18'(abx_q); end
          2'd1:    begin mul_a = 18'(aby_q); mul_b = 18'(aby_q); end
          2'd2:    begin mul_a = 18'(apx_q); mul_b = 18'(abx_q); end
          default: begin mul_a = 18'(apy_q); mul_b = 18'(aby_q); end
        endcase
      end
      plht_pkg::DP_OFS: begin
        mul_a = $signed({2'b00, t_q});
        mul_b = (ofs_delta < 0) ? -ofs_delta : ofs_delta;
      end
      plht_pkg::DP_SQ: begin
        mul_a = cmd_i.step[0] ? dy_q : dx_q;
        mul_b = cmd_i.step[0] ? dy_q : dx_q;
      end
      default: ;
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign rnd      = 17'(({4'd0, $unsigned(prod[31:0])} + 36'd32768) >> 16);
  assign rem2     = {rem_q[DW-2:0], 1'b0};
  assign sq_sum   = d2_q + DW'($unsigned(prod));
  assign root_try = res_q + bit_q;
  assign d2x4     = {best_q, 2'b00};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stroke_q <= 12'd16;
      pad_q    <= 8'd16;
      grip_q   <= 10'd160;
      count_q  <= '0;
      drop_q   <= 1'b0;
      done_o   <= 1'b0;
    end else begin
      done_o <= (cmd_i.op == plht_pkg::DP_OUT);
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          plht_pkg::CFG_STROKE: stroke_q <= cfg_data_i;
          plht_pkg::CFG_PAD:    pad_q    <= cfg_data_i[7:0];
          plht_pkg::CFG_GRIP:   grip_q   <= cfg_data_i[9:0];
          default: ;
        endcase
      end
      if (cmd_i.op == plht_pkg::DP_CLEAR) begin
        count_q <= '0;
        drop_q  <= 1'b0;
      end else if (cmd_i.op == plht_pkg::DP_APPEND) begin
        if (ram_we) count_q <= count_q + CW'(1);
        else        drop_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      plht_pkg::DP_QINIT: begin
        px_q        <= coord_x_i;
        py_q        <= coord_y_i;
        seg_q       <= '0;
        best_q      <= '1;
        outer2_q    <= 28'(outer) * 28'(outer);
        inner2_q    <= 28'(inner_mag) * 28'(inner_mag);
        inner_neg_q <= inner[14];
      end
      plht_pkg::DP_LOAD: begin
        abx_q <= 17'($signed(rd_b[31:16])) - 17'($signed(rd_a[31:16]));
        aby_q <= 17'($signed(rd_b[15:0]))  - 17'($signed(rd_a[15:0]));
        apx_q <= 17'(px_q) - 17'($signed(rd_a[31:16]));
        apy_q <= 17'(py_q) - 17'($signed(rd_a[15:0]));
        bpx_q <= 17'(px_q) - 17'($signed(rd_b[31:16]));
        bpy_q <= 17'(py_q) - 17'($signed(rd_b[15:0]));
      end
      plht_pkg::DP_MAC: begin
        case (cmd_i.step)
          2'd0:    len2_q <= 36'($unsigned(prod));
          2'd1:    len2_q <= len2_q + 36'($unsigned(prod));
          2'd2:    dot_q  <= 37'(prod);
          default: dot_q  <= dot_q + 37'(prod);
        endcase
      end
      plht_pkg::DP_CHK: begin
        rem_q <= $unsigned(dot_q);
        t_q   <= '0;
        if (len2_q == '0 || dot_q <= 0) begin
          dx_q <= 18'(apx_q);
          dy_q <= 18'(apy_q);
        end else begin
          dx_q <= 18'(bpx_q);
          dy_q <= 18'(bpy_q);
        end
      end
      plht_pkg::DP_DIV: begin
        if (rem2 >= DW'(len2_q)) begin
          rem_q <= rem2 - DW'(len2_q);
          t_q   <= {t_q[14:0], 1'b1};
        end else begin
          rem_q <= rem2;
          t_q   <= {t_q[14:0], 1'b0};
        end
      end
      plht_pkg::DP_OFS: begin
        if (cmd_i.step[0]) dy_q <= ofs_ap - ((ofs_delta < 0) ? -18'(rnd) : 18'(rnd));
        else               dx_q <= ofs_ap - ((ofs_delta < 0) ? -18'(rnd) : 18'(rnd));
      end
      plht_pkg::DP_SQ: begin
        if (!cmd_i.step[0]) d2_q <= DW'($unsigned(prod));
        else if (sq_sum < best_q) best_q <= sq_sum;
      end
      plht_pkg::DP_NEXT: begin
        seg_q <= seg_q + AW'(1);
        v_q   <= best_q;
        res_q <= '0;
        bit_q <= DW'(1) << (2 * (plht_pkg::ROOT_STEPS - 1));
      end
      plht_pkg::DP_ROOT: begin
        if (v_q >= root_try) begin
          v_q   <= v_q - root_try;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      plht_pkg::DP_OUT: begin
        overflowed_o <= drop_q;
        if (status_o.cnt_lt2) begin
          hit_o          <= 1'b0;
          min_distance_o <= 16'hFFFF;
          no_segment_o   <= 1'b1;
        end else begin
          hit_o <= (d2x4 <= 39'(outer2_q)) &&
                   !(!inner_neg_q && (d2x4 < 39'(inner2_q)));
          min_distance_o <= (res_q > DW'(16'hFFFF)) ? 16'hFFFF : res_q[15:0];
          no_segment_o   <= 1'b0;
        end
      end
      default: ;
    endcase
  end
endmodule

>>> design/polyline_edge_hit_test.sv
// Polyline edge hit test, top level: controller plus datapath.
// Clear/append do not raise busy. A query with fewer than two vertices goes straight
// to the result; else each segment is measured (16-step serial divide when needed), then a root.
// One item at a time: start is taken only while busy is low; done_o pulses 1 cycle.
// Async active-low reset: no vertices, flag clear, registers 16/16/160.
// Depends on plht_pkg, plht_ctrl, plht_dp.
`timescale 1ns / 1ps
module polyline_edge_hit_test #(
  parameter int MAX_VERTICES = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 opcode_i,
  input  logic signed [15:0]         coord_x_i,
  input  logic signed [15:0]         coord_y_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [1:0]                 cfg_index_i,
  input  logic [plht_pkg::CFG_W-1:0] cfg_data_i,
  output logic                       done_o,
  output logic                       hit_o,
  output logic [15:0]                min_distance_o,
  output logic                       no_segment_o,
  output logic                       overflowed_o
);
  plht_pkg::dp_cmd_t    cmd;
  plht_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  plht_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (opcode_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  plht_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .coord_x_i      (coord_x_i),
    .coord_y_i      (coord_y_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .hit_o          (hit_o),
    .min_distance_o (min_distance_o),
    .no_segment_o   (no_segment_o),
    .overflowed_o   (overflowed_o)
  );
endmodule

>>> design/plht_checker.sv
// Port-level checks for polyline_edge_hit_test, bound to the top level.
// Depends on plht_pkg.
`timescale 1ns / 1ps
module plht_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  opcode_i,
  input logic        done_o,
  input logic        hit_o,
  input logic [15:0] min_distance_o,
  input logic        no_segment_o
);
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result beat repeated");
  a_cmd_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i != plht_pkg::OP_QUERY) |=> !busy)
    else $error("clear/append held busy");
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i == plht_pkg::OP_QUERY) |=> busy)
    else $error("query not started");
  a_noseg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && no_segment_o) |-> (!hit_o && min_distance_o == 16'hFFFF))
    else $error("bad empty result");
endmodule

bind polyline_edge_hit_test plht_checker u_plht_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .opcode_i       (opcode_i),
  .done_o         (done_o),
  .hit_o          (hit_o),
  .min_distance_o (min_distance_o),
  .no_segment_o   (no_segment_o)
);

>>> tb/sv/tb_polyline_edge_hit_test.sv
// Self-checking testbench for polyline_edge_hit_test: directed table, then random
// polylines, queries and register settings, checked against a behavioral predictor.
// Depends on plht_pkg and the polyline_edge_hit_test RTL.
`timescale 1ns / 1ps
module tb_polyline_edge_hit_test;

  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam logic [1:0] CFG_NONE   = 2'd3;
  localparam int         DEPTH      = 256;
  localparam int         STALL_MAX  = 50000;
  localparam int         CW         = plht_pkg::CFG_W;

  typedef struct {
    logic        hit;
    logic [15:0] mdist;
    logic        noseg;
    logic        ovf;
  } hit_res_t;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] x;
    logic [15:0] y;
    logic        pinned;
    hit_res_t    res;
  } row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          opcode_i = plht_pkg::OP_CLEAR;
  logic signed [15:0]  coord_x_i = '0;
  logic signed [15:0]  coord_y_i = '0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [1:0]          cfg_index_i = plht_pkg::CFG_STROKE;
  logic [CW-1:0]       cfg_data_i = '0;
  logic                done_o;
  logic                hit_o;
  logic [15:0]         min_distance_o;
  logic                no_segment_o;
  logic                overflowed_o;

  polyline_edge_hit_test u_top (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // predictor state
  int          pv_x[DEPTH];
  int          pv_y[DEPTH];
  int          pv_count;
  logic        pv_drop;
  logic [11:0] reg_stroke;
  logic [7:0]  reg_pad;
  logic [9:0]  reg_grip;

  hit_res_t    expected_hits[$];
  logic        pin_valid = 1'b0;
  hit_res_t    pin_res;
  int          errors = 0;
  int          idle_cycles = 0;
  logic        quiet = 1'b0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint round_offset(longint t, longint delta);
    longint m;
    longint r;
    m = (delta < 0) ? -delta : delta;
    r = (t * m + 32768) >>> 16;
    return (delta < 0) ? -r : r;
  endfunction

  function automatic longint seg_dist_sq(longint px, longint py, longint ax, longint ay,
                                         longint bx, longint by);
    longint abx, aby, apx, apy, len2, dot, dx, dy, t;
    abx = bx - ax; aby = by - ay;
    apx = px - ax; apy = py - ay;
    len2 = abx * abx + aby * aby;
    dot = apx * abx + apy * aby;
    if (len2 == 0 || dot <= 0) begin
      dx = apx; dy = apy;
    end else if (dot >= len2) begin
      dx = px - bx; dy = py - by;
    end else begin
      t = (dot <<< 16) / len2;
      dx = apx - round_offset(t, abx);
      dy = apy - round_offset(t, aby);
    end
    return dx * dx + dy * dy;
  endfunction

  function automatic hit_res_t query_hit(int px, int py);
    hit_res_t        r;
    longint          best, d2, outer, inner;
    longint unsigned root;
    r.ovf = pv_drop;
    if (pv_count < 2) begin
      r.hit = 1'b0; r.mdist = 16'hFFFF; r.noseg = 1'b1;
      return r;
    end
    best = 64'h7FFF_FFFF_FFFF_FFFF;
    for (int i = 0; i + 1 < pv_count; i++) begin
      d2 = seg_dist_sq(px, py, pv_x[i], pv_y[i], pv_x[i+1], pv_y[i+1]);
      if (d2 < best) best = d2;
    end
    outer = longint'(reg_stroke) + 2 * longint'(reg_pad);
    inner = outer - longint'(reg_grip);
    r.hit = (best * 4 <= outer * outer);
    if (r.hit && inner >= 0 && best * 4 < inner * inner) r.hit = 1'b0;
    root = int_sqrt(best);
    r.mdist = (root > 65535) ? 16'hFFFF : root[15:0];
    r.noseg = 1'b0;
    return r;
  endfunction

  // accepted beats: update predictor, check results
  always @(posedge clk_i) begin
    hit_res_t e;
    logic     seen;
    seen = 1'b0;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        seen = 1'b1;
        case (cfg_index_i)
          plht_pkg::CFG_STROKE: reg_stroke = cfg_data_i[11:0];
          plht_pkg::CFG_PAD:    reg_pad = cfg_data_i[7:0];
          plht_pkg::CFG_GRIP:   reg_grip = cfg_data_i[9:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        seen = 1'b1;
        case (opcode_i)
          plht_pkg::OP_CLEAR: begin
            pv_count = 0; pv_drop = 1'b0;
          end
          plht_pkg::OP_APPEND: begin
            if (pv_count < DEPTH) begin
              pv_x[pv_count] = coord_x_i; pv_y[pv_count] = coord_y_i;
              pv_count++;
            end else begin
              pv_drop = 1'b1;
            end
          end
          plht_pkg::OP_QUERY: begin
            e = query_hit(coord_x_i, coord_y_i);
            expected_hits.insert(expected_hits.size(), pin_valid ? pin_res : e);
          end
          default: ;
        endcase
      end
      if (done_o) begin
        seen = 1'b1;
        if (expected_hits.size() == 0) begin
          $error("result beat with no query pending");
          errors++;
        end else begin
          e = expected_hits.pop_front();
          if (hit_o !== e.hit) begin
            $error("hit: expected %0d, actual %0d", e.hit, hit_o); errors++;
          end
          if (min_distance_o !== e.mdist) begin
            $error("min_distance: expected %0d, actual %0d", e.mdist, min_distance_o);
            errors++;
          end
          if (no_segment_o !== e.noseg) begin
            $error("no_segment: expected %0d, actual %0d", e.noseg, no_segment_o);
            errors++;
          end
          if (overflowed_o !== e.ovf) begin
            $error("overflowed: expected %0d, actual %0d", e.ovf, overflowed_o);
            errors++;
          end
        end
      end
      idle_cycles <= seen ? 0 : idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= STALL_MAX) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // all tasks enter and leave at a falling edge
  task automatic send(logic [1:0] op, logic [15:0] x, logic [15:0] y);
    if (!quiet && $urandom_range(99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    start <= 1'b1;
    opcode_i <= op;
    coord_x_i <= x;
    coord_y_i <= y;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk_i);
    while (expected_hits.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // leaves valid high; the caller drops it after the last beat
  task automatic write_reg(logic [1:0] idx, logic [CW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  task automatic set_band(logic [CW-1:0] sw, logic [CW-1:0] pd, logic [CW-1:0] gr);
    drain();
    write_reg(plht_pkg::CFG_STROKE, sw);
    write_reg(plht_pkg::CFG_PAD, pd);
    write_reg(plht_pkg::CFG_GRIP, gr);
    if ($urandom_range(3) == 0) write_reg(CFG_NONE, CW'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] near(int c, int spread);
    int v;
    v = c + $urandom_range(2 * spread) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  row_t     plan[$];
  hit_res_t none_res;
  hit_res_t far_res;

  initial begin
    int n, k, sent, spread;
    none_res = '{hit: 1'b0, mdist: 16'hFFFF, noseg: 1'b1, ovf: 1'b0};
    far_res  = '{hit: 1'b0, mdist: 16'hFFFF, noseg: 1'b0, ovf: 1'b0};
    reg_stroke = 12'd16; reg_pad = 8'd16; reg_grip = 10'd160;
    pv_count = 0; pv_drop = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    plan = '{
      '{plht_pkg::OP_QUERY,  16'h0000, 16'h0000, 1'b1, none_res},
      '{plht_pkg::OP_APPEND, 16'h0000, 16'h0000, 1'b0, none_res},
      '{plht_pkg::OP_QUERY,  16'h0010, 16'h0000, 1'b1, none_res},
      '{plht_pkg::OP_APPEND, 16'h0000, 16'h0000, 1'b0, none_res},
      '{plht_pkg::OP_QUERY,  16'h0010, 16'h0005, 1'b0, none_res},
      '{plht_pkg::OP_APPEND, 16'h0100, 16'h0040, 1'b0, none_res},
      '{plht_pkg::OP_QUERY,  16'h0080, 16'h0030, 1'b0, none_res},
      '{plht_pkg::OP_QUERY,  16'h0200, 16'h0050, 1'b0, none_res},
      '{plht_pkg::OP_QUERY,  16'hFF00, 16'hFFF0, 1'b0, none_res},
      '{OP_IGNORED,          16'h1234, 16'h5678, 1'b0, none_res},
      '{plht_pkg::OP_QUERY,  16'h0010, 16'h0000, 1'b0, none_res},
      '{plht_pkg::OP_CLEAR,  16'hFFFF, 16'hFFFF, 1'b0, none_res},
      '{plht_pkg::OP_APPEND, 16'h8000, 16'h8000, 1'b0, none_res},
      '{plht_pkg::OP_APPEND, 16'h8000, 16'h8001, 1'b0, none_res},
      '{plht_pkg::OP_QUERY,  16'h7FFF, 16'h7FFF, 1'b1, far_res},
      '{plht_pkg::OP_APPEND, 16'h7FFF, 16'h7FFF, 1'b0, none_res},
      '{plht_pkg::OP_QUERY,  16'h7FFF, 16'h8000, 1'b0, none_res},
      '{plht_pkg::OP_QUERY,  16'h8000, 16'h7FFF, 1'b0, none_res},
      '{plht_pkg::OP_QUERY,  16'h0000, 16'h0000, 1'b0, none_res},
      '{plht_pkg::OP_CLEAR,  16'h0000, 16'h0000, 1'b0, none_res},
      '{plht_pkg::OP_QUERY,  16'h7FFF, 16'h8000, 1'b1, none_res}
    };
    foreach (plan[i]) begin
      pin_valid = plan[i].pinned;
      pin_res = plan[i].res;
      send(plan[i].op, plan[i].x, plan[i].y);
    end
    pin_valid = 1'b0;

    // band extremes: largest outer edge with zero grip, then zero outer edge
    set_band(12'hFFF, 12'h0FF, 12'h000);
    send(plht_pkg::OP_APPEND, 16'h0000, 16'h0000);
    send(plht_pkg::OP_APPEND, 16'h0400, 16'h0000);
    send(plht_pkg::OP_QUERY, 16'h0200, 16'h0100);
    send(plht_pkg::OP_QUERY, 16'h0200, 16'h0000);
    set_band(12'h000, 12'h000, 12'h3FF);
    send(plht_pkg::OP_QUERY, 16'h0200, 16'h0000);
    send(plht_pkg::OP_QUERY, 16'h0200, 16'h0001);
    set_band(12'd16, 12'd16, 12'd160);

    sent = 0;
    while (sent < 400) begin
      quiet = (sent >= 20 && sent < 100);
      if (sent % 60 == 0 && sent != 0) begin
        case ($urandom_range(3))
          0: set_band(CW'($urandom_range(4095)), CW'($urandom_range(255)),
                      CW'($urandom_range(1023)));
          1: set_band(CW'($urandom_range(64)), CW'($urandom_range(16)),
                      CW'($urandom_range(1023)));
          2: set_band(CW'($urandom_range(400)), CW'($urandom_range(64)),
                      CW'($urandom_range(600)));
          default: set_band(12'd16, 12'd16, 12'd160);
        endcase
      end
      // one polyline (usually after a clear), then queries near it or at random
      if ($urandom_range(4) != 0) begin
        send(plht_pkg::OP_CLEAR, 16'($urandom), 16'($urandom));
        sent++;
      end
      n = ($urandom_range(9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
      spread = ($urandom_range(2) == 0) ? 32767 : 200;
      k = int'($urandom_range(60000)) - 30000;
      for (int i = 0; i < n; i++) begin
        send(plht_pkg::OP_APPEND, near(k, spread), near(k, spread));
        sent++;
      end
      repeat ($urandom_range(2, 6)) begin
        if (pv_count > 0 && $urandom_range(3) != 0) begin
          k = $urandom_range(pv_count - 1);
          send(plht_pkg::OP_QUERY, near(pv_x[k], 60), near(pv_y[k], 60));
        end else if ($urandom_range(5) == 0) begin
          send(OP_IGNORED, 16'($urandom), 16'($urandom));
        end else begin
          send(plht_pkg::OP_QUERY, 16'($urandom), 16'($urandom));
        end
        sent++;
      end
      if (sent > 100 && sent < 140) begin
        // fill past capacity (the last appends drop), then query the full polyline twice
        send(plht_pkg::OP_CLEAR, 16'h0000, 16'h0000);
        for (int i = 0; i < DEPTH + 3; i++) begin
          send(plht_pkg::OP_APPEND, near(i * 64 - 8192, 100), near(0, 3000));
        end
        send(plht_pkg::OP_QUERY, near(0, 300), near(0, 300));
        send(plht_pkg::OP_QUERY, 16'($urandom), 16'($urandom));
        sent += DEPTH + 6;
      end
      if (sent % 90 < 8) drain();
    end

    drain();
    repeat (40) @(negedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> polyline_edge_hit_test.f
design/plht_pkg.sv
design/plht_ram.sv
design/plht_ctrl.sv
design/plht_dp.sv
design/polyline_edge_hit_test.sv
design/plht_checker.sv
tb/sv/tb_polyline_edge_hit_test.sv
